@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the occupancy marker RTL.
// Depends on a clk and an active-low rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LROM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LROM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/lrom_pkg.sv @@
// Shared types and constants for the lidar ray occupancy marker.
// No dependencies.
package lrom_pkg;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] rot_w;
    logic signed [15:0] rot_z;
    logic        [15:0] ray_range;
    logic signed [15:0] ray_angle;
    logic               ray_is_max;
    logic        [7:0]  read_x;
    logic        [7:0]  read_y;
  } lrom_in_t;

  typedef struct packed {
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
    logic               cell_value;
    logic        [2:0]  status;
  } lrom_out_t;

  typedef enum logic [1:0] {
    K_READ,
    K_DISABLED,
    K_MAXRANGE,
    K_RAY
  } lrom_kind_t;

  typedef struct packed {
    lrom_kind_t kind;
    lrom_in_t   item;
  } lrom_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lrom_qstat_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ATAN,
    S_PREP,
    S_ROT,
    S_TRIG,
    S_SUM,
    S_SCALE,
    S_LOAD,
    S_DIV,
    S_FIN,
    S_CHECK,
    S_MARK,
    S_READ
  } lrom_state_t;

  localparam logic [2:0] ST_MARKED    = 3'd0;
  localparam logic [2:0] ST_MAXRANGE  = 3'd1;
  localparam logic [2:0] ST_OUTSIDE   = 3'd2;
  localparam logic [2:0] ST_DISABLED  = 3'd3;
  localparam logic [2:0] ST_READ_DONE = 3'd4;

  localparam int QDEPTH        = 2;
  localparam int CORDIC_STEPS  = 20;
  localparam int CW            = 34;   // CORDIC datapath width
  localparam int SW            = 52;   // endpoint sum width
  localparam int RECIP_SHIFT   = 32;

  // ceil(2^32 / 100): exact quotient by 100 for dividends below 2^30
  localparam logic [25:0] RECIP_100    = 26'd42949673;

  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [29:0] CORDIC_GAIN  = 30'd652032874;
  localparam logic [29:0] RAD_TO_BAM   = 30'd683565276;
  localparam logic [16:0] POS_OFFSET   = 17'd12800;   // 50 m in Q7.8

  localparam logic [31:0] ATAN_BAM [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304
  };

endpackage

@@ hw/rtl/lrom_front.sv @@
// Front end: holds the enable register and classifies incoming items.
// Depends on lrom_pkg.
module lrom_front import lrom_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  lrom_in_t    in_item,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  lrom_qstat_t q_stat,
  input  logic        clearing,
  output logic        q_push,
  output lrom_cmd_t   q_cmd
);

  logic map_enable_r;
  logic map_enable_nxt;

  always_comb begin
    map_enable_nxt = cfg_we ? cfg_wdata : map_enable_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_enable_r <= 1'b0;
    end else begin
      map_enable_r <= map_enable_nxt;
    end
  end

  assign full   = q_stat.full | clearing;
  assign q_push = push & ~full;

  always_comb begin
    q_cmd.item = in_item;
    if (in_item.opcode) begin
      q_cmd.kind = K_READ;
    end else if (!map_enable_r) begin
      q_cmd.kind = K_DISABLED;
    end else if (in_item.ray_is_max) begin
      q_cmd.kind = K_MAXRANGE;
    end else begin
      q_cmd.kind = K_RAY;
    end
  end

endmodule

@@ hw/rtl/lrom_queue.sv @@
// Short command queue between front and back.
// Depends on lrom_pkg.
module lrom_queue import lrom_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_push,
  input  lrom_cmd_t   q_cmd,
  input  logic        q_pop,
  output lrom_cmd_t   q_head,
  output lrom_qstat_t q_stat
);

  localparam int QAW = $clog2(QDEPTH);

  lrom_cmd_t        slot_r [QDEPTH];
  logic [QAW-1:0]   wptr_r, wptr_nxt;
  logic [QAW-1:0]   rptr_r, rptr_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = q_push ? QAW'(wptr_r + 1'b1) : wptr_r;
    rptr_nxt = q_pop  ? QAW'(rptr_r + 1'b1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (q_push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!q_push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      slot_r[wptr_r] <= q_cmd;
    end
  end

  assign q_head       = slot_r[rptr_r];
  assign q_stat.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);

endmodule

@@ hw/rtl/lrom_back.sv @@
// Back end: CORDIC sequencer, endpoint scaling, grid memory and result register.
// Depends on lrom_pkg.
module lrom_back import lrom_pkg::*; #(
  parameter int MAP_SIDE = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  lrom_cmd_t   q_head,
  input  lrom_qstat_t q_stat,
  output logic        q_pop,
  output logic        clearing,
  input  logic        pop,
  output logic        empty,
  output lrom_out_t   out_item
);

  localparam int AW = $clog2(MAP_SIDE);
  localparam int MW = $clog2(MAP_SIDE + 1);
  localparam int DW = 14 + MW;
  localparam logic [MW-1:0] SIDE = MW'(MAP_SIDE);

  lrom_state_t state_r, state_nxt;
  lrom_cmd_t   cmd_r, cmd_nxt;
  logic signed [CW-1:0] xr_r, xr_nxt, yr_r, yr_nxt, zr_r, zr_nxt;
  logic signed [CW-1:0] trig_x_r, trig_x_nxt, trig_y_r, trig_y_nxt;
  logic [31:0]  acc_r, acc_nxt, ray_r, ray_nxt;
  logic [4:0]   step_r, step_nxt;
  logic         zq_r, zq_nxt, flip_r, flip_nxt, axis_r, axis_nxt, neg_r, neg_nxt;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic [25+MW:0] plo_r, plo_nxt, phi_r, phi_nxt;
  logic [DW-1:0]  dreg_r, dreg_nxt, quo_r, quo_nxt;
  logic signed [15:0] cell_x_r, cell_x_nxt, cell_y_r, cell_y_nxt;
  logic [AW-1:0]  clr_r, clr_nxt;
  lrom_out_t      out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic [MAP_SIDE-1:0] grid_mem [MAP_SIDE];
  logic [MAP_SIDE-1:0] rd_row_r;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [MAP_SIDE-1:0] mem_wdata;

  // helper signals
  logic signed [46:0]   ray_prod;
  logic signed [CW-1:0] dx, dy, x0, y0;
  logic [31:0]          yaw, theta, theta_t;
  logic signed [16:0]   pos17;
  logic signed [CW-1:0] trig_sel;
  logic signed [50:0]   rprod;
  logic [SW-1:0]        mag;
  logic [51+MW:0]       prod;
  logic [DW+25:0]       qprod;
  logic [15:0]          qq;
  logic                 in_x, in_y, rd_ok, start, out_set;

  assign ray_prod = 47'(q_head.item.ray_angle) * $signed({17'b0, RAD_TO_BAM});
  assign dx = yr_r >>> step_r;
  assign dy = xr_r >>> step_r;
  assign x0 = {{(CW-30){q_head.item.rot_z[15]}}, q_head.item.rot_z, 14'b0};
  assign y0 = {{(CW-30){q_head.item.rot_w[15]}}, q_head.item.rot_w, 14'b0};
  assign yaw     = {acc_r[30:0], 1'b0} + HALF_TURN;
  assign theta   = ray_r - (zq_r ? HALF_TURN : yaw);
  assign theta_t = theta + QUARTER_TURN;
  assign pos17   = (axis_r ? {cmd_r.item.pos_y[15], cmd_r.item.pos_y}
                           : {cmd_r.item.pos_x[15], cmd_r.item.pos_x}) + $signed(POS_OFFSET);
  assign trig_sel = axis_r ? trig_y_r : trig_x_r;
  assign rprod    = $signed({1'b0, cmd_r.item.ray_range}) * trig_sel;
  assign mag      = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  assign prod     = {phi_r, 26'b0} + (52+MW)'(plo_r);
  assign qprod    = (DW+26)'(dreg_r) * (DW+26)'(RECIP_100);
  assign qq       = neg_r ? 16'(-quo_r[15:0]) : quo_r[15:0];
  assign in_x     = !cell_x_r[15] && (16'(cell_x_r) < 16'(MAP_SIDE));
  assign in_y     = !cell_y_r[15] && (16'(cell_y_r) < 16'(MAP_SIDE));
  assign rd_ok    = (16'(q_head.item.read_x) < 16'(MAP_SIDE)) &&
                    (16'(q_head.item.read_y) < 16'(MAP_SIDE));
  assign start    = !q_stat.empty && (!out_valid_r || pop);

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    xr_nxt     = xr_r;
    yr_nxt     = yr_r;
    zr_nxt     = zr_r;
    trig_x_nxt = trig_x_r;
    trig_y_nxt = trig_y_r;
    acc_nxt    = acc_r;
    ray_nxt    = ray_r;
    step_nxt   = step_r;
    zq_nxt     = zq_r;
    flip_nxt   = flip_r;
    axis_nxt   = axis_r;
    neg_nxt    = neg_r;
    sum_nxt    = sum_r;
    plo_nxt    = plo_r;
    phi_nxt    = phi_r;
    dreg_nxt   = dreg_r;
    quo_nxt    = quo_r;
    cell_x_nxt = cell_x_r;
    cell_y_nxt = cell_y_r;
    clr_nxt    = clr_r;
    out_nxt    = out_r;
    out_set    = 1'b0;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = cell_x_r[AW-1:0];
    mem_raddr  = cell_x_r[AW-1:0];
    mem_wdata  = rd_row_r | (MAP_SIDE'(1) << cell_y_r[AW-1:0]);

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = AW'(clr_r + 1'b1);
        if (clr_r == AW'(MAP_SIDE - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          q_pop   = 1'b1;
          cmd_nxt = q_head;
          unique case (q_head.kind)
            K_READ: begin
              cell_x_nxt = 16'(q_head.item.read_x);
              cell_y_nxt = 16'(q_head.item.read_y);
              if (rd_ok) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(q_head.item.read_x);
                state_nxt = S_READ;
              end else begin
                out_set = 1'b1;
                out_nxt = '{cell_x: 16'(q_head.item.read_x),
                            cell_y: 16'(q_head.item.read_y),
                            cell_value: 1'b0, status: ST_OUTSIDE};
              end
            end
            K_DISABLED: begin
              out_set = 1'b1;
              out_nxt = '{cell_x: '0, cell_y: '0, cell_value: 1'b0, status: ST_DISABLED};
            end
            K_MAXRANGE: begin
              out_set = 1'b1;
              out_nxt = '{cell_x: '0, cell_y: '0, cell_value: 1'b0, status: ST_MAXRANGE};
            end
            K_RAY: begin
              ray_nxt  = ray_prod[43:12];
              zq_nxt   = (q_head.item.rot_w == '0) && (q_head.item.rot_z == '0);
              step_nxt = '0;
              if (q_head.item.rot_z[15]) begin
                xr_nxt  = -x0;
                yr_nxt  = -y0;
                acc_nxt = HALF_TURN;
              end else begin
                xr_nxt  = x0;
                yr_nxt  = y0;
                acc_nxt = '0;
              end
              state_nxt = S_ATAN;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ATAN: begin
        if (yr_r > 0) begin
          xr_nxt  = xr_r + dx;
          yr_nxt  = yr_r - dy;
          acc_nxt = acc_r + ATAN_BAM[step_r];
        end else begin
          xr_nxt  = xr_r - dx;
          yr_nxt  = yr_r + dy;
          acc_nxt = acc_r - ATAN_BAM[step_r];
        end
        step_nxt = step_r + 1'b1;
        if (step_r == 5'(CORDIC_STEPS - 1)) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        // fold into [-pi/2, pi/2) so the rotation converges
        flip_nxt = theta_t[31];
        zr_nxt   = theta_t[31] ? {{2{~theta[31]}}, theta + HALF_TURN}
                               : {{2{theta[31]}}, theta};
        xr_nxt   = {{(CW-30){1'b0}}, CORDIC_GAIN};
        yr_nxt   = '0;
        step_nxt = '0;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        if (!zr_r[CW-1]) begin
          xr_nxt = xr_r - dx;
          yr_nxt = yr_r + dy;
          zr_nxt = zr_r - $signed({2'b0, ATAN_BAM[step_r]});
        end else begin
          xr_nxt = xr_r + dx;
          yr_nxt = yr_r - dy;
          zr_nxt = zr_r + $signed({2'b0, ATAN_BAM[step_r]});
        end
        step_nxt = step_r + 1'b1;
        if (step_r == 5'(CORDIC_STEPS - 1)) begin
          state_nxt = S_TRIG;
        end
      end
      S_TRIG: begin
        trig_x_nxt = flip_r ? -xr_r : xr_r;
        trig_y_nxt = flip_r ? -yr_r : yr_r;
        axis_nxt   = 1'b0;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        sum_nxt   = $signed({{5{pos17[16]}}, pos17, 30'b0}) + $signed({rprod[50], rprod});
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        neg_nxt   = sum_r[SW-1];
        plo_nxt   = (26+MW)'(mag[25:0]) * (26+MW)'(SIDE);
        phi_nxt   = (26+MW)'(mag[51:26]) * (26+MW)'(SIDE);
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        dreg_nxt  = prod[51+MW:38];
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // divide by the cell pitch with a reciprocal multiply
        quo_nxt   = DW'(qprod >> RECIP_SHIFT);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!axis_r) begin
          cell_x_nxt = qq;
          axis_nxt   = 1'b1;
          state_nxt  = S_SUM;
        end else begin
          cell_y_nxt = qq;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (in_x && in_y) begin
          mem_re    = 1'b1;
          state_nxt = S_MARK;
        end else begin
          out_set   = 1'b1;
          out_nxt   = '{cell_x: cell_x_r, cell_y: cell_y_r, cell_value: 1'b0,
                        status: ST_OUTSIDE};
          state_nxt = S_IDLE;
        end
      end
      S_MARK: begin
        mem_we    = 1'b1;
        out_set   = 1'b1;
        out_nxt   = '{cell_x: cell_x_r, cell_y: cell_y_r, cell_value: 1'b0,
                      status: ST_MARKED};
        state_nxt = S_IDLE;
      end
      S_READ: begin
        out_set   = 1'b1;
        out_nxt   = '{cell_x: cell_x_r, cell_y: cell_y_r,
                      cell_value: rd_row_r[cell_y_r[AW-1:0]], status: ST_READ_DONE};
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (out_set) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    xr_r     <= xr_nxt;
    yr_r     <= yr_nxt;
    zr_r     <= zr_nxt;
    trig_x_r <= trig_x_nxt;
    trig_y_r <= trig_y_nxt;
    acc_r    <= acc_nxt;
    ray_r    <= ray_nxt;
    step_r   <= step_nxt;
    zq_r     <= zq_nxt;
    flip_r   <= flip_nxt;
    axis_r   <= axis_nxt;
    neg_r    <= neg_nxt;
    sum_r    <= sum_nxt;
    plo_r    <= plo_nxt;
    phi_r    <= phi_nxt;
    dreg_r   <= dreg_nxt;
    quo_r    <= quo_nxt;
    cell_x_r <= cell_x_nxt;
    cell_y_r <= cell_y_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_row_r <= grid_mem[mem_raddr];
    end
  end

  assign clearing = (state_r == S_CLEAR);
  assign empty    = ~out_valid_r;
  assign out_item = out_r;

endmodule

@@ hw/rtl/lidar_ray_occupancy_marker.sv @@
// Lidar ray occupancy marker, top level: front end, command queue, back end.
// Depends on lrom_pkg, lrom_front, lrom_queue, lrom_back and assert_macros.svh.
//
// Marks the endpoint cell of each lidar ray in a MAP_SIDE x MAP_SIDE one-bit
// occupancy grid and answers single-cell reads. After reset the grid is swept
// clear one row per cycle, and full stays high until the sweep ends; cfg
// writes are taken throughout. Both channels behave as queues: push a
// transaction while full is low, pop a result while empty is low. A two-entry
// command queue lets the front keep taking transactions while the back works.
// From leaving the queue, out-of-grid reads, disabled and max-range rays go
// straight to the result register; in-grid reads first fetch the grid row. A
// mapped ray runs an iterative 20-step CORDIC for the yaw (atan2), a second
// 20-step CORDIC for cos/sin, then per axis a sum, a scale by MAP_SIDE, a
// shift, a reciprocal multiply for the divide by 100 and a sign fix, then a
// bounds check and a read-modify-write of the grid row, skipped when the
// endpoint is outside the grid. One CORDIC datapath serves both passes, and
// the back takes a new transaction only once it is idle and the result
// register is free or being popped.
// Grid cell (x, y) is bit y of row x. Out-of-grid endpoints report status 2 and
// write nothing. cfg_wdata is map_enable; it is sampled as a ray is accepted.
`include "assert_macros.svh"

module lidar_ray_occupancy_marker import lrom_pkg::*; #(
  parameter int MAP_SIDE = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  // ray / read transactions
  input  logic      push,
  output logic      full,
  input  lrom_in_t  in_item,
  // results
  input  logic      pop,
  output logic      empty,
  output lrom_out_t out_item,
  // map_enable register
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  lrom_qstat_t q_stat;
  lrom_cmd_t   q_cmd, q_head;
  logic        q_push, q_pop, clearing;

  lrom_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .clearing  (clearing),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  lrom_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_cmd  (q_cmd),
    .q_pop  (q_pop),
    .q_head (q_head),
    .q_stat (q_stat)
  );

  lrom_back #(.MAP_SIDE(MAP_SIDE)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (q_head),
    .q_stat   (q_stat),
    .q_pop    (q_pop),
    .clearing (clearing),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

  // no transaction gets in while the grid is being swept
  `LROM_ASSERT_IMP(a_clear_blocks, clearing, full, "input open during grid clear")
  // the back never pulls from an empty queue
  `LROM_ASSERT_IMP(a_no_underrun, q_pop, !q_stat.empty, "pop from empty command queue")
  // only reads carry an occupancy bit
  `LROM_ASSERT_IMP(a_value_on_read, !empty && out_item.cell_value,
    out_item.status == ST_READ_DONE, "cell_value set on a ray result")
  // a marked cell lies inside the grid
  `LROM_ASSERT_IMP(a_marked_in_grid, !empty && out_item.status == ST_MARKED,
    !out_item.cell_x[15] && !out_item.cell_y[15] &&
    out_item.cell_x < 16'(MAP_SIDE) && out_item.cell_y < 16'(MAP_SIDE),
    "marked cell outside grid")

endmodule
